### hdl/url_chk_pkg.sv
package url_chk_pkg;

    typedef enum logic [2:0] {
        PH_SCHEME  = 3'd0,
        PH_HSTART  = 3'd1,
        PH_NAME    = 3'd2,
        PH_BRACKET = 3'd3,
        PH_AFTERBR = 3'd4,
        PH_PORT    = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        V_UNDEC  = 2'd0,
        V_ACCEPT = 2'd1,
        V_REJECT = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       url_end;
    } res_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_P      = 8'h70;

    localparam logic [3:0] LEN_TACACS  = 4'd9;
    localparam logic [3:0] LEN_TACPLUS = 4'd10;
    localparam logic [3:0] POS_FORK    = 4'd3;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], 8'h2e, 8'h2d};
    endfunction

    // ASCII upper case to lower case, everything else unchanged
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5a]}) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [3:0] scheme_len(input logic sel);
        return sel ? LEN_TACPLUS : LEN_TACACS;
    endfunction

    // expected scheme byte; zero past the end of either string
    function automatic logic [7:0] scheme_char(input logic sel, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (!sel) begin
            case (pos)
                4'd0:    ch = 8'h74;
                4'd1:    ch = 8'h61;
                4'd2:    ch = 8'h63;
                4'd3:    ch = 8'h61;
                4'd4:    ch = 8'h63;
                4'd5:    ch = 8'h73;
                4'd6:    ch = 8'h3a;
                4'd7:    ch = 8'h2f;
                4'd8:    ch = 8'h2f;
                default: ch = 8'h00;
            endcase
        end
        else begin
            case (pos)
                4'd0:    ch = 8'h74;
                4'd1:    ch = 8'h61;
                4'd2:    ch = 8'h63;
                4'd3:    ch = 8'h70;
                4'd4:    ch = 8'h6c;
                4'd5:    ch = 8'h75;
                4'd6:    ch = 8'h73;
                4'd7:    ch = 8'h3a;
                4'd8:    ch = 8'h2f;
                4'd9:    ch = 8'h2f;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

### hdl/url_syntax_checker_unit.sv
// URL syntax checker. Feed a URL one byte per word on char_code and end it
// with a zero byte; every byte returns one result word with a running verdict
// (0 undecided, 1 accepted, 2 rejected) and url_end set on the zero byte,
// after which the checker is armed for the next URL. The scheme must be
// tacacs:// or tacplus:// in any letter case, then a host (bracketed hex and
// colons, or letters, digits, dots and dashes), then an optional decimal port.
// Throughput is one byte per clock while out_stall is low: each word passes an
// input register, the parse logic against the state registers, and a result
// register, from which the result word is offered to the consumer. in_stall
// rises only while a finished result sits unread with out_stall high.
module url_syntax_checker_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    output logic       url_end
);
    import url_chk_pkg::*;

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;

    logic out_ready;
    logic fire;
    res_t step_res;

    // byte in the input register moves on whenever the result slot frees up
    assign fire     = in_valid_reg && out_ready;
    assign in_stall = in_valid_reg && !out_ready;

    always_comb
    begin
        if (!in_stall)
            in_valid_next = in_valid;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            char_reg <= char_code;
    end

    url_chk_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .char_in (char_reg),
        .res     (step_res)
    );

    url_chk_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (step_res),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .url_end   (url_end)
    );

endmodule

### hdl/url_chk_step.sv
// Parser state and one-byte step logic; state advances when fire is high.
module url_chk_step
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        char_in,
    output url_chk_pkg::res_t res
);
    import url_chk_pkg::*;

    phase_t     phase_reg,  phase_next;
    logic [3:0] pos_reg,    pos_next;
    logic       choice_reg, choice_next;
    verdict_t   dec_reg,    dec_next;

    logic [7:0] lc;
    logic       ch_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCHEME;
            pos_reg    <= '0;
            choice_reg <= 1'b0;
            dec_reg    <= V_UNDEC;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            choice_reg <= choice_next;
            dec_reg    <= dec_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        choice_next = choice_reg;
        dec_next    = dec_reg;
        res.verdict = dec_reg;
        res.url_end = 1'b0;
        lc          = to_lower(char_in);
        ch_sel      = choice_reg | ((pos_reg == POS_FORK) && (lc == CH_P));

        if (char_in == CH_NUL)
        begin
            // end of URL: resolve open phases, then re-arm
            case (phase_reg)
                PH_SCHEME, PH_BRACKET:           res.verdict = V_REJECT;
                PH_HSTART, PH_NAME, PH_AFTERBR,
                PH_PORT:                         res.verdict = V_ACCEPT;
                default:                         res.verdict = dec_reg;
            endcase
            res.url_end = 1'b1;
            phase_next  = PH_SCHEME;
            pos_next    = '0;
            choice_next = 1'b0;
            dec_next    = V_UNDEC;
        end
        else
        begin
            case (phase_reg)
                PH_SCHEME:
                begin
                    choice_next = ch_sel;
                    if ((pos_reg >= scheme_len(ch_sel)) || (lc != scheme_char(ch_sel, pos_reg)))
                    begin
                        dec_next   = V_REJECT;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                        if ((pos_reg + 4'd1) == scheme_len(ch_sel))
                            phase_next = PH_HSTART;
                    end
                end
                PH_HSTART, PH_NAME:
                begin
                    if ((phase_reg == PH_HSTART) && (char_in == CH_LBRACK))
                        phase_next = PH_BRACKET;
                    else if (char_in == CH_COLON)
                        phase_next = PH_PORT;
                    else if (char_in == CH_SLASH)
                    begin
                        dec_next   = V_ACCEPT;
                        phase_next = PH_DONE;
                    end
                    else if (is_name(char_in))
                        phase_next = PH_NAME;
                    else
                    begin
                        dec_next   = V_REJECT;
                        phase_next = PH_DONE;
                    end
                end
                PH_BRACKET:
                begin
                    if (char_in == CH_RBRACK)
                        phase_next = PH_AFTERBR;
                    else if (!(is_hex(char_in) || (char_in == CH_COLON)))
                    begin
                        dec_next   = V_REJECT;
                        phase_next = PH_DONE;
                    end
                end
                PH_AFTERBR:
                begin
                    if (char_in == CH_COLON)
                        phase_next = PH_PORT;
                    else
                    begin
                        dec_next   = V_ACCEPT;
                        phase_next = PH_DONE;
                    end
                end
                PH_PORT:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        dec_next   = V_ACCEPT;
                        phase_next = PH_DONE;
                    end
                    else if (!is_digit(char_in))
                    begin
                        dec_next   = V_REJECT;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            res.verdict = dec_next;
        end
    end

endmodule

### hdl/url_chk_out.sv
// Result register with valid/stall toward the consumer.
module url_chk_out
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  url_chk_pkg::res_t res,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        verdict,
    output logic              url_end
);
    import url_chk_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign verdict   = res_reg.verdict;
    assign url_end   = res_reg.url_end;

endmodule

### hdl/url_chk_checker.sv
// Port-level checks for the URL checker.
module url_chk_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] char_code,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] verdict,
    input logic       url_end
);
    import url_chk_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(url_end))
        else $error("result word changed under stall");

    // verdict code three is never produced
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == V_UNDEC) || (verdict == V_ACCEPT) || (verdict == V_REJECT))
        else $error("illegal verdict code");

    // input backpressure only when the result slot is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a zero byte taken with no stall anywhere shows as url_end once it has passed the input and result registers
    a_end_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (char_code == CH_NUL) && !out_stall ##1 !out_stall
        |=> out_valid && url_end)
        else $error("end of URL not reported");

endmodule

bind url_syntax_checker_unit url_chk_checker u_chk (.*);

### bench/url_syntax_checker_unit_tb.sv
module url_syntax_checker_unit_tb;

    import url_chk_pkg::*;

    // Watchdog, in clock cycles.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 310;

    // Running model of the checker plus the queue of result words still owed.
    class url_scoreboard;
        phase_t     ph;
        logic [3:0] matched;     // scheme bytes matched so far
        logic       plus_form;   // 1: tacplus://, 0: tacacs://
        verdict_t   so_far;
        res_t       waiting[$];
        int         errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            ph        = PH_SCHEME;
            matched   = 4'd0;
            plus_form = 1'b0;
            so_far    = V_UNDEC;
        endfunction

        function void settle(verdict_t v);
            so_far = v;
            ph     = PH_DONE;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_hexdig(logic [7:0] c);
            return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function bit is_host_char(logic [7:0] c);
            return is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                || c == "." || c == "-";
        endfunction

        function string scheme_text();
            return plus_form ? "tacplus://" : "tacacs://";
        endfunction

        // Host byte after the scheme or inside a name host.
        function void host_byte(logic [7:0] c);
            if (c == CH_COLON)
                ph = PH_PORT;
            else if (c == CH_SLASH)
                settle(V_ACCEPT);
            else if (is_host_char(c))
                ph = PH_NAME;
            else
                settle(V_REJECT);
        endfunction

        // Called for each accepted input word; queues the result word it causes.
        function void note_word(logic [7:0] c);
            logic [7:0] lc;
            string      s;
            res_t       r;
            r.url_end = 1'b0;
            if (c == CH_NUL)
            begin
                // terminator: open states resolve, decided ones repeat
                r.verdict = so_far;
                if (ph != PH_DONE && ph <= PH_PORT)
                    r.verdict = (ph == PH_SCHEME || ph == PH_BRACKET) ? V_REJECT : V_ACCEPT;
                r.url_end = 1'b1;
                waiting.push_back(r);
                restart();
                return;
            end
            case (ph)
                PH_SCHEME:
                begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
                    // fourth byte picks between the two schemes
                    if (matched == POS_FORK && lc == CH_P)
                        plus_form = 1'b1;
                    s = scheme_text();
                    if (matched >= s.len() || lc != s[matched])
                        settle(V_REJECT);
                    else
                    begin
                        matched = matched + 4'd1;
                        if (matched == s.len())
                            ph = PH_HSTART;
                    end
                end
                PH_HSTART:
                begin
                    if (c == CH_LBRACK)
                        ph = PH_BRACKET;
                    else
                        host_byte(c);
                end
                PH_NAME:
                    host_byte(c);
                PH_BRACKET:
                begin
                    if (c == CH_RBRACK)
                        ph = PH_AFTERBR;
                    else if (!(is_hexdig(c) || c == CH_COLON))
                        settle(V_REJECT);
                end
                PH_AFTERBR:
                begin
                    if (c == CH_COLON)
                        ph = PH_PORT;
                    else
                        settle(V_ACCEPT);
                end
                PH_PORT:
                begin
                    if (c == CH_SLASH)
                        settle(V_ACCEPT);
                    else if (!is_dec(c))
                        settle(V_REJECT);
                end
                default: ;
            endcase
            r.verdict = so_far;
            waiting.push_back(r);
        endfunction

        // Called for each accepted result word.
        function void check_result(logic [1:0] v, logic e);
            res_t want;
            if (waiting.size() == 0)
            begin
                $display("%0t: unexpected result word, verdict %0d url_end %0d",
                         $time, v, e);
                errors++;
                return;
            end
            want = waiting.pop_front();
            if (v !== want.verdict)
            begin
                $display("%0t: verdict mismatch, expected %0d, actual %0d",
                         $time, want.verdict, v);
                errors++;
            end
            if (e !== want.url_end)
            begin
                $display("%0t: url_end mismatch, expected %0d, actual %0d",
                         $time, want.url_end, e);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] verdict;
    logic       url_end;

    url_scoreboard sb = new();

    logic [7:0] url_q[$];      // bytes of the URL about to be sent
    bit         calm = 1'b1;   // when set, neither side idles
    int         cycle_count = 0;

    url_syntax_checker_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .url_end   (url_end)
    );

    always #5 clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sender: optional idle gap, then hold the word until accepted.
    // Runs from a rising edge and returns on the edge that took the word.
    task automatic send_word(input logic [7:0] c);
        int idle;
        idle = calm ? 0 : $urandom_range(0, 5);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(c);
    endtask

    task automatic flush_url();
        foreach (url_q[i])
            send_word(url_q[i]);
        url_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            url_q.push_back(s[i]);
    endtask

    // Directed URL: the text plus its terminator.
    task automatic check_text(input string s);
        push_text(s);
        url_q.push_back(CH_NUL);
        flush_url();
    endtask

    // Scheme with random letter case.
    task automatic push_scheme(input bit plus);
        string      s;
        logic [7:0] c;
        s = plus ? "tacplus://" : "tacacs://";
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1))
                c = c - 8'h20;
            url_q.push_back(c);
        end
    endtask

    function automatic logic [7:0] rand_host_char();
        case ($urandom_range(0, 4))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h61 + 8'($urandom_range(0, 25));
            2:       return 8'h41 + 8'($urandom_range(0, 25));
            3:       return ".";
            default: return "-";
        endcase
    endfunction

    function automatic logic [7:0] rand_hex_char();
        case ($urandom_range(0, 3))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h61 + 8'($urandom_range(0, 5));
            2:       return 8'h41 + 8'($urandom_range(0, 5));
            default: return CH_COLON;
        endcase
    endfunction

    task automatic push_port();
        int n;
        url_q.push_back(CH_COLON);
        n = $urandom_range(0, 5);
        repeat (n) url_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_path();
        int n;
        url_q.push_back(CH_SLASH);
        n = $urandom_range(0, 4);
        repeat (n) url_q.push_back(8'($urandom_range(1, 255)));
    endtask

    // Mostly well-formed URLs with random content; some broken, some noise.
    task automatic build_url();
        int mode;
        int n;
        int k;
        mode = $urandom_range(0, 9);
        if (mode == 9)
        begin
            // raw noise, zeros included
            n = $urandom_range(1, 10);
            repeat (n) url_q.push_back(8'($urandom_range(0, 255)));
            url_q.push_back(CH_NUL);
            return;
        end
        push_scheme(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
        begin
            url_q.push_back(CH_LBRACK);
            n = $urandom_range(0, 6);
            repeat (n) url_q.push_back(rand_hex_char());
            url_q.push_back(CH_RBRACK);
            k = $urandom_range(0, 4);
            if (k <= 1)
                push_port();
            else if (k == 2)
            begin
                // any byte but a colon after the bracket ends the check
                url_q.push_back(8'($urandom_range(1, 255)));
                n = $urandom_range(0, 3);
                repeat (n) url_q.push_back(8'($urandom_range(1, 255)));
            end
        end
        else
        begin
            n = $urandom_range(0, 8);
            repeat (n) url_q.push_back(rand_host_char());
            if ($urandom_range(0, 2) != 0)
                push_port();
        end
        if ($urandom_range(0, 2) == 0)
            push_path();
        if (mode == 7)
        begin
            // cut short anywhere
            k = $urandom_range(0, url_q.size() - 1);
            while (url_q.size() > k)
                void'(url_q.pop_back());
        end
        else if (mode == 8)
            url_q[$urandom_range(0, url_q.size() - 1)] = 8'($urandom_range(1, 255));
        url_q.push_back(CH_NUL);
    endtask

    // Receiver: optional stall, then take the next result word.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(verdict, url_end);
        end
    end

    initial
    begin
        int sent;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed URLs, run back to back first, then with idling.
        check_text("");                          // empty URL: ends in scheme
        check_text("tac");                       // ends inside scheme
        check_text("TaCaCs://");                 // empty host
        calm = 1'b0;
        check_text("tacplus://[12");             // missing closing bracket
        check_text("tacplus://[]");
        check_text("TACPLUS://[fe80::1A]:49");
        check_text("tacacs://[ab]x/zz");         // byte after bracket, rest ignored
        check_text("tacacs://srv-1.example:");   // empty port
        check_text("tacacs://host:4949/a b");    // slash after port
        check_text("tacacs://host/x");           // slash after host
        check_text("tacpacs://h");               // fork taken, then mismatch
        check_text("tacacs://h_st");             // bad host byte
        check_text("tacacs://h:4a");             // bad port byte
        check_text("tacacs://\311");             // high byte in host
        check_text("\364ac");                    // high byte in scheme
        check_text("tacacs://[\377]");           // high byte in brackets
        check_text("tacacs://1:\200");           // high byte in port
        check_text("tacacs://[a]:");

        // Random URLs, with stretches of no idling.
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            build_url();
            sent += url_q.size();
            calm = ($urandom_range(0, 3) == 0);
            flush_url();
        end
        in_valid <= 1'b0;

        while (sb.waiting.size() != 0)
            @(posedge clk);
        // leave room for any stray word
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
